FILE: design/alal_pkg.sv
// Shared types, codes and constants for the ambient light lux engine.
package alal_pkg;

    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 27;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 5;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_LUX  = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;

    localparam logic [2:0] CFG_LSB_SCALE  = 3'd0;
    localparam logic [2:0] CFG_MODE       = 3'd1;
    localparam logic [2:0] CFG_FIX_GAIN   = 3'd2;
    localparam logic [2:0] CFG_FIX_TIME   = 3'd3;
    localparam logic [2:0] CFG_LOW_LIMIT  = 3'd4;
    localparam logic [2:0] CFG_HIGH_LIMIT = 3'd5;

    localparam logic [1:0] MODE_PLAIN    = 2'd0;
    localparam logic [1:0] MODE_CORR     = 2'd1;
    localparam logic [1:0] MODE_AUTO     = 2'd2;
    localparam logic [1:0] MODE_AUTO_ALT = 2'd3;

    localparam logic [2:0] TIME_MAX = 3'd5;
    localparam logic [2:0] TIME_START = 3'd2;
    localparam logic [1:0] GAIN_TOP = 2'd3;

    localparam logic [39:0] LUX_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [35:0] COEF_A = 36'd11092950;
    localparam logic [46:0] COEF_B = 47'd676793746;
    localparam logic [30:0] COEF_C = 31'd349988;
    localparam logic [35:0] COEF_D = 36'd65687;

    typedef enum logic [2:0] {
        PH_IDLE, PH_FIXED, PH_FIRST, PH_RAISE, PH_LOWER
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PLAIN, ST_T1, ST_T2, ST_T3, ST_Y
    } t_state;

    function automatic logic [2:0] gain_shift(input logic [1:0] g);
        logic [2:0] s;
        case (g)
            2'd0: s = 3'd4;
            2'd1: s = 3'd3;
            2'd2: s = 3'd1;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: design/alal_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module alal_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [alal_pkg::MUL_A_W-1:0]  i_a,
    input  logic [alal_pkg::MUL_B_W-1:0]  i_b,
    output logic                          o_done,
    output logic [alal_pkg::MUL_P_W-1:0]  o_prod
);
    import alal_pkg::*;

    logic [MUL_P_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [MUL_P_W-1:0]   r_acc;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= MUL_P_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without a running product");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("start while multiplier busy");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("busy with empty count");

endmodule

FILE: design/ambient_light_autorange_lux.sv
// Ambient light lux engine: auto-ranging control, lux scaling and correction.
// Read requests and ignored counts: result valid the cycle after the transfer.
// Plain lux: one serial multiply, result registered once the multiplier reports done.
// Corrected lux: five serial multiplies on the shared multiplier, or one if the plain product saturates.
// One item at a time; the next item is taken once the previous result is out.
// Synchronous active-low reset restores register defaults and the idle phase.
module ambient_light_autorange_lux (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // als_count[15:0]
    input  logic [0:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // gain_index[1:0], time_index[4:2], lux_value[44:5],
                                       // was_corrected[45], zero fill
    output logic [1:0]  m_axis_tuser   // result_kind
);
    import alal_pkg::*;

    logic [23:0] r_lsb_scale;
    logic [1:0]  r_mode, r_fix_gain;
    logic [2:0]  r_fix_time;
    logic [15:0] r_low, r_high;

    t_phase      r_phase, n_phase;
    t_state      r_state, n_state;
    logic [1:0]  r_gain, n_gain;
    logic [2:0]  r_time, n_time;
    logic        r_use, n_use;

    logic [MUL_A_W-1:0] r_opa, n_opa;
    logic [MUL_B_W-1:0] r_opb, n_opb;
    logic        r_start, n_start;
    logic        r_sign, n_sign;

    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_okind, n_okind, r_ogain, n_ogain;
    logic [2:0]  r_otime, n_otime;
    logic [39:0] r_olux, n_olux;
    logic        r_ocorr, n_ocorr;

    logic               mul_done;
    logic [MUL_P_W-1:0] mul_prod;
    logic               in_xfer;

    alal_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign s_axis_tready = (r_state == ST_IDLE) && !r_start && (!r_ovalid || m_axis_tready);
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsb_scale <= 24'd60398;
            r_mode      <= MODE_PLAIN;
            r_fix_gain  <= 2'd0;
            r_fix_time  <= TIME_START;
            r_low       <= 16'd100;
            r_high      <= 16'd10000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LSB_SCALE:  r_lsb_scale <= i_cfg_data;
                CFG_MODE:       r_mode      <= i_cfg_data[1:0];
                CFG_FIX_GAIN:   r_fix_gain  <= i_cfg_data[1:0];
                CFG_FIX_TIME:   r_fix_time  <= i_cfg_data[2:0];
                CFG_LOW_LIMIT:  r_low       <= i_cfg_data[15:0];
                CFG_HIGH_LIMIT: r_high      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        t_phase     ph;
        logic       corr;
        logic       fin;
        logic [2:0] tcl;
        logic [3:0] sh;
        logic [63:0] sum;
        logic [46:0] u;
        logic [30:0] m;

        n_phase = r_phase;
        n_state = r_state;
        n_gain  = r_gain;
        n_time  = r_time;
        n_use   = r_use;
        n_opa   = r_opa;
        n_opb   = r_opb;
        n_start = 1'b0;
        n_sign  = r_sign;
        n_ovalid = (r_ovalid && m_axis_tready) ? 1'b0 : r_ovalid;
        n_okind = r_okind;
        n_ogain = r_ogain;
        n_otime = r_otime;
        n_olux  = r_olux;
        n_ocorr = r_ocorr;
        ph   = r_phase;
        corr = r_use;
        fin  = 1'b0;
        tcl  = (r_time > TIME_MAX) ? TIME_MAX : r_time;
        sh   = 4'(TIME_MAX - tcl) + 4'(gain_shift(r_gain));
        sum  = '0;
        u    = '0;
        m    = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_olux  = '0;
                    n_ocorr = 1'b0;
                    n_okind = KIND_READ;
                    n_ovalid = 1'b1;
                    if (!s_axis_tuser[0]) begin
                        if (r_mode[1]) begin
                            n_gain  = 2'd0;
                            n_time  = TIME_START;
                            n_use   = 1'b0;
                            n_phase = PH_FIRST;
                        end else begin
                            n_gain  = r_fix_gain;
                            n_time  = (r_fix_time > TIME_MAX) ? TIME_MAX : r_fix_time;
                            n_use   = (r_mode == MODE_CORR);
                            n_phase = PH_FIXED;
                        end
                    end else begin
                        if (ph == PH_FIRST) begin
                            corr = s_axis_tdata > r_low;
                            ph   = corr ? PH_LOWER : PH_RAISE;
                        end
                        n_use   = corr;
                        n_phase = ph;
                        case (ph)
                            PH_FIXED: fin = 1'b1;
                            PH_RAISE: begin
                                if (s_axis_tdata <= r_low &&
                                    !(r_gain == GAIN_TOP && r_time >= TIME_MAX)) begin
                                    if (r_gain < GAIN_TOP) n_gain = r_gain + 1'b1;
                                    else n_time = r_time + 1'b1;
                                end else begin
                                    fin = 1'b1;
                                end
                            end
                            PH_LOWER: begin
                                if (s_axis_tdata > r_high && r_time > 3'd0) begin
                                    n_time = r_time - 1'b1;
                                end else begin
                                    fin = 1'b1;
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                n_okind = KIND_IDLE;
                            end
                        endcase
                        if (fin) begin
                            n_phase  = PH_IDLE;
                            n_okind  = KIND_LUX;
                            n_ocorr  = corr;
                            n_ovalid = 1'b0;
                            n_opa    = MUL_A_W'(r_lsb_scale) << sh;
                            n_opb    = MUL_B_W'(s_axis_tdata);
                            n_start  = 1'b1;
                            n_state  = ST_PLAIN;
                        end
                    end
                    n_ogain = n_gain;
                    n_otime = n_time;
                end
            end
            ST_PLAIN: begin
                if (mul_done) begin
                    sum = 64'(mul_prod) + 64'd32768;
                    if (!r_ocorr) begin
                        n_olux = 40'(sum[63:16]);
                        n_ovalid = 1'b1;
                        n_state = ST_IDLE;
                    end else if (sum[63:43] != '0) begin
                        n_olux = LUX_MAX;
                        n_ovalid = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_opb   = sum[42:16];
                        n_opa   = COEF_A;
                        n_start = 1'b1;
                        n_state = ST_T1;
                    end
                end
            end
            ST_T1: begin
                if (mul_done) begin
                    sum = 64'(mul_prod) + 64'd32768;
                    u   = sum[62:16];
                    n_sign = u < COEF_B;
                    n_opa  = n_sign ? MUL_A_W'(COEF_B - u) : MUL_A_W'(u - COEF_B);
                    n_start = 1'b1;
                    n_state = ST_T2;
                end
            end
            ST_T2: begin
                if (mul_done) begin
                    sum = 64'(mul_prod) + 64'h8000_0000;
                    m   = sum[62:32];
                    if (r_sign) begin
                        n_opa = (m >= COEF_C) ? '0 : MUL_A_W'(COEF_C - m);
                    end else begin
                        n_opa = MUL_A_W'(m) + MUL_A_W'(COEF_C);
                    end
                    n_start = 1'b1;
                    n_state = ST_T3;
                end
            end
            ST_T3: begin
                if (mul_done) begin
                    sum = 64'(mul_prod) + 64'h80_0000;
                    n_opa = sum[59:24] + COEF_D;
                    n_start = 1'b1;
                    n_state = ST_Y;
                end
            end
            ST_Y: begin
                if (mul_done) begin
                    sum = 64'(mul_prod) + 64'd32768;
                    n_olux = (sum[63:56] != '0) ? LUX_MAX : sum[55:16];
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_state  <= ST_IDLE;
            r_gain   <= 2'd0;
            r_time   <= TIME_START;
            r_use    <= 1'b0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_state  <= n_state;
            r_gain   <= n_gain;
            r_time   <= n_time;
            r_use    <= n_use;
            r_start  <= n_start;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_sign  <= n_sign;
        r_okind <= n_okind;
        r_ogain <= n_ogain;
        r_otime <= n_otime;
        r_olux  <= n_olux;
        r_ocorr <= n_ocorr;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {2'b00, r_ocorr, r_olux, r_otime, r_ogain};

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == ST_IDLE) else $error("input taken while computing");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> r_state != ST_IDLE) else $error("multiply started while idle");
    a_no_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_ovalid) else $error("result pending during compute");
    a_lux_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_okind != KIND_LUX) |-> (r_olux == '0 && !r_ocorr))
        else $error("nonzero lux on non-lux result");

endmodule
